// ===== rtl/sfi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sfi_pkg;

   // pixel and blend formats
   localparam int PIX_W  = 16;
   localparam int STEP_W = 17;
   localparam int SUM_W  = PIX_W + 2;
   localparam int PROD_W = 2 * STEP_W + 1;
   localparam logic [STEP_W-1:0] ONE_Q16 = STEP_W'(65536);

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = STEP_W;
   localparam int COUNT_W    = 8;
   localparam int SIZE_W     = 8;

   localparam logic [CSR_ADDR_W-1:0] REG_PASS_COUNT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_BLEND_STEP = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_WIDTH      = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_HEIGHT     = 2'd3;

   localparam logic [COUNT_W-1:0] RST_PASS_COUNT = 8'd10;
   localparam logic [STEP_W-1:0]  RST_BLEND_STEP = 17'd6554;
   localparam logic [SIZE_W-1:0]  RST_WIDTH      = 8'd128;
   localparam logic [SIZE_W-1:0]  RST_HEIGHT     = 8'd128;

   // default frame bounds
   localparam int DEF_MAX_WIDTH  = 128;
   localparam int DEF_MAX_HEIGHT = 128;

   // request kinds
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   // filter sequencer states, one memory read per fetch state
   typedef enum logic [3:0] {
      ENG_IDLE,
      ENG_RD_C,
      ENG_RD_R,
      ENG_RD_L,
      ENG_RD_D,
      ENG_RD_U,
      ENG_LAST,
      ENG_SEL,
      ENG_MUL,
      ENG_WR
   } eng_state_type;

   // filter status seen by the top level
   typedef struct packed {
      logic busy;
      logic done;
      logic src_b;
      logic final_b;
   } eng_status_type;

endpackage

`default_nettype wire

// ===== rtl/sfi_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/sfi_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfi_engine #(
   parameter int MAX_WIDTH  = sfi_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sfi_pkg::DEF_MAX_HEIGHT,
   parameter int XW         = $clog2(MAX_WIDTH + 1),
   parameter int YW         = $clog2(MAX_HEIGHT + 1),
   parameter int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [XW-1:0]                eff_w,
   input  wire logic [YW-1:0]                eff_h,
   input  wire logic [sfi_pkg::STEP_W-1:0]   step,
   input  wire logic [sfi_pkg::COUNT_W-1:0]  pass_count,
   output sfi_pkg::eng_status_type           status,
   output logic                              rd_en,
   output logic      [ADDR_W-1:0]            rd_addr,
   input  wire logic [sfi_pkg::PIX_W-1:0]    rd_data,
   output logic                              wr_en,
   output logic      [ADDR_W-1:0]            wr_addr,
   output logic      [sfi_pkg::PIX_W-1:0]    wr_data
);

   import sfi_pkg::*;

   eng_state_type state_ff, state_in;

   logic [XW-1:0]      x_ff, x_in;
   logic [YW-1:0]      y_ff, y_in;
   logic [ADDR_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0]  up_ff, up_in;
   logic [ADDR_W-1:0]  dn_ff, dn_in;
   logic               src_b_ff, src_b_in;
   logic [COUNT_W-1:0] passes_done_ff, passes_done_in;

   logic [PIX_W-1:0]        c_ff, c_in;
   logic [PIX_W-1:0]        min_ff, min_in;
   logic [PIX_W-1:0]        max_ff, max_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [PIX_W-1:0]        pick_ff, pick_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic              last_x, last_y, last_pass;
   logic [XW-1:0]     lf_x, rt_x;
   logic [ADDR_W-1:0] w_ext, c_addr;
   logic [SUM_W-1:0]  four_c;
   logic signed [PIX_W+1:0]  diff;
   logic signed [PROD_W-1:0] blend;

   // pixel position and mirrored neighbours
   assign last_x    = (x_ff == eff_w - XW'(1));
   assign last_y    = (y_ff == eff_h - YW'(1));
   assign last_pass = (passes_done_ff + COUNT_W'(1) == pass_count);
   assign lf_x      = (x_ff == '0) ? XW'(1) : x_ff - XW'(1);
   assign rt_x      = last_x ? eff_w - XW'(2) : x_ff + XW'(1);
   assign w_ext     = ADDR_W'(eff_w);
   assign c_addr    = row_ff + ADDR_W'(x_ff);

   // laplacian sign and blend arithmetic
   assign four_c = {c_ff, 2'b00};
   assign diff   = $signed({2'b00, pick_ff}) - $signed({2'b00, c_ff});
   assign blend  = $signed({{(PROD_W-PIX_W-16){1'b0}}, c_ff, 16'h0000})
                   + prod_ff + PROD_W'(32768);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ENG_IDLE: if (start) state_in = ENG_RD_C;
         ENG_RD_C: state_in = ENG_RD_R;
         ENG_RD_R: state_in = ENG_RD_L;
         ENG_RD_L: state_in = ENG_RD_D;
         ENG_RD_D: state_in = ENG_RD_U;
         ENG_RD_U: state_in = ENG_LAST;
         ENG_LAST: state_in = ENG_SEL;
         ENG_SEL:  state_in = ENG_MUL;
         ENG_MUL:  state_in = ENG_WR;
         ENG_WR: begin
            if (last_x && last_y && last_pass) state_in = ENG_IDLE;
            else                               state_in = ENG_RD_C;
         end
         default:  state_in = ENG_IDLE;
      endcase
   end

   // memory port and status outputs
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = c_addr;
      wr_en   = 1'b0;
      wr_addr = c_addr;
      wr_data = blend[PIX_W+15:16];
      case (state_ff)
         ENG_RD_C: rd_en = 1'b1;
         ENG_RD_R: begin
            rd_en   = 1'b1;
            rd_addr = row_ff + ADDR_W'(rt_x);
         end
         ENG_RD_L: begin
            rd_en   = 1'b1;
            rd_addr = row_ff + ADDR_W'(lf_x);
         end
         ENG_RD_D: begin
            rd_en   = 1'b1;
            rd_addr = dn_ff + ADDR_W'(x_ff);
         end
         ENG_RD_U: begin
            rd_en   = 1'b1;
            rd_addr = up_ff + ADDR_W'(x_ff);
         end
         ENG_WR:   wr_en = 1'b1;
         default:  rd_en = 1'b0;
      endcase
      status.busy    = (state_ff != ENG_IDLE);
      status.done    = (state_ff == ENG_WR) && last_x && last_y && last_pass;
      status.src_b   = src_b_ff;
      status.final_b = ~src_b_ff;
   end

   // datapath: position counters, running sum and min/max over the fetched neighbours, pick and blend product
   always_comb begin
      x_in           = x_ff;
      y_in           = y_ff;
      row_in         = row_ff;
      up_in          = up_ff;
      dn_in          = dn_ff;
      src_b_in       = src_b_ff;
      passes_done_in = passes_done_ff;
      c_in           = c_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      sum_in         = sum_ff;
      pick_in        = pick_ff;
      prod_in        = prod_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (start) begin
               x_in           = '0;
               y_in           = '0;
               row_in         = '0;
               up_in          = w_ext;
               dn_in          = w_ext;
               src_b_in       = 1'b0;
               passes_done_in = '0;
            end
         end
         ENG_RD_R: begin
            c_in   = rd_data;
            min_in = rd_data;
            max_in = rd_data;
            sum_in = '0;
         end
         ENG_RD_L, ENG_RD_D, ENG_RD_U, ENG_LAST: begin
            sum_in = sum_ff + SUM_W'(rd_data);
            if (rd_data < min_ff) min_in = rd_data;
            if (rd_data > max_ff) max_in = rd_data;
         end
         ENG_SEL: begin
            if (sum_ff > four_c)      pick_in = min_ff;
            else if (sum_ff < four_c) pick_in = max_ff;
            else                      pick_in = c_ff;
         end
         ENG_MUL: begin
            prod_in = PROD_W'($signed({1'b0, step}) * diff);
         end
         ENG_WR: begin
            if (!last_x) begin
               x_in = x_ff + XW'(1);
            end else begin
               x_in = '0;
               if (last_y) begin
                  // end of pass: swap frames
                  y_in           = '0;
                  row_in         = '0;
                  up_in          = w_ext;
                  dn_in          = w_ext;
                  src_b_in       = ~src_b_ff;
                  passes_done_in = passes_done_ff + COUNT_W'(1);
               end else begin
                  y_in   = y_ff + YW'(1);
                  row_in = row_ff + w_ext;
                  up_in  = row_ff;
                  if (y_ff + YW'(2) == eff_h) dn_in = row_ff;
                  else                        dn_in = row_ff + {w_ext[ADDR_W-2:0], 1'b0};
               end
            end
         end
         default: c_in = c_ff;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ENG_IDLE;
         src_b_ff       <= 1'b0;
         passes_done_ff <= '0;
      end else begin
         state_ff       <= state_in;
         src_b_ff       <= src_b_in;
         passes_done_ff <= passes_done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      row_ff  <= row_in;
      up_ff   <= up_in;
      dn_ff   <= dn_in;
      c_ff    <= c_in;
      min_ff  <= min_in;
      max_ff  <= max_in;
      sum_ff  <= sum_in;
      pick_ff <= pick_in;
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ===== rtl/shock_filter_iterated.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake               payload
// req_      in   req_tvalid/req_tready   tdata pixel_in, tuser opcode
// rsp_      out  rsp_tvalid/rsp_tready   tdata pixel_out, tlast last_pixel
// csr_      in   csr_we                  csr_addr index, csr_wdata value
//
// loads and reads are accepted back to back while req_tready is high; a read
// result appears in the cycle after acceptance, from the registered frame
// memory read port. after the last load the filter runs pass_count passes,
// reading each pixel and its four neighbours in turn through the single
// source read port; req_tready is low meanwhile and while a result waits.
// synchronous active-high reset clears control state; frames are not cleared.

module shock_filter_iterated #(
   parameter int MAX_WIDTH  = sfi_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sfi_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [sfi_pkg::PIX_W-1:0]       req_tdata,   // [15:0] pixel_in
   input  wire logic [0:0]                      req_tuser,   // [0] opcode
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [sfi_pkg::PIX_W-1:0]       rsp_tdata,   // [15:0] pixel_out
   output logic                                 rsp_tlast,
   input  wire logic                            csr_we,
   input  wire logic [sfi_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [sfi_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import sfi_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int XW     = $clog2(MAX_WIDTH + 1);
   localparam int YW     = $clog2(MAX_HEIGHT + 1);

   logic [COUNT_W-1:0] pass_count_ff, pass_count_in;
   logic [STEP_W-1:0]  blend_step_ff, blend_step_in;
   logic [SIZE_W-1:0]  width_ff, width_in;
   logic [SIZE_W-1:0]  height_ff, height_in;

   logic              cur_b_ff, cur_b_in;
   logic [ADDR_W-1:0] load_pos_ff, load_pos_in;
   logic [ADDR_W-1:0] read_pos_ff, read_pos_in;
   logic              pend_ff, pend_in;
   logic              last_ff, last_in;
   logic              sel_ff, sel_in;

   logic [XW-1:0]     eff_w;
   logic [YW-1:0]     eff_h;
   logic [STEP_W-1:0] step_sat;
   logic [CNT_W-1:0]  count;
   logic [ADDR_W-1:0] count_m1;
   logic [ADDR_W-1:0] load_addr, read_addr;
   logic              load_last, read_last;
   logic              req_acc, load_acc, read_acc, start;

   eng_status_type    eng;
   logic              eng_rd_en, eng_wr_en;
   logic [ADDR_W-1:0] eng_rd_addr, eng_wr_addr;
   logic [PIX_W-1:0]  eng_wr_data, eng_rd_data;

   logic              a_we, a_re, b_we, b_re;
   logic [ADDR_W-1:0] a_waddr, a_raddr, b_raddr;
   logic [PIX_W-1:0]  a_wdata, a_q, b_q;

   // effective sizes, step and pixel count
   always_comb begin
      if (width_ff < SIZE_W'(2))             eff_w = XW'(2);
      else if (32'(width_ff) > MAX_WIDTH)    eff_w = XW'(MAX_WIDTH);
      else                                   eff_w = XW'(width_ff);
      if (height_ff < SIZE_W'(2))            eff_h = YW'(2);
      else if (32'(height_ff) > MAX_HEIGHT)  eff_h = YW'(MAX_HEIGHT);
      else                                   eff_h = YW'(height_ff);
      step_sat = (blend_step_ff > ONE_Q16) ? ONE_Q16 : blend_step_ff;
   end

   assign count    = CNT_W'(eff_w * eff_h);
   assign count_m1 = ADDR_W'(count - CNT_W'(1));

   // request handshake
   assign req_tready = !eng.busy && (!pend_ff || rsp_tready);
   assign req_acc    = req_tvalid && req_tready;
   assign load_acc   = req_acc && (req_tuser[0] == OP_LOAD);
   assign read_acc   = req_acc && (req_tuser[0] == OP_READ);

   // positions clipped to the current image
   assign load_addr = (CNT_W'(load_pos_ff) >= count) ? count_m1 : load_pos_ff;
   assign read_addr = (CNT_W'(read_pos_ff) >= count) ? '0 : read_pos_ff;
   assign load_last = (load_addr == count_m1);
   assign read_last = (read_addr == count_m1);
   assign start     = load_acc && load_last && (pass_count_ff != '0);

   // configuration writes
   always_comb begin
      pass_count_in = pass_count_ff;
      blend_step_in = blend_step_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_PASS_COUNT: pass_count_in = csr_wdata[COUNT_W-1:0];
            REG_BLEND_STEP: blend_step_in = csr_wdata[STEP_W-1:0];
            REG_WIDTH:      width_in      = csr_wdata[SIZE_W-1:0];
            REG_HEIGHT:     height_in     = csr_wdata[SIZE_W-1:0];
            default:        pass_count_in = pass_count_ff;
         endcase
      end
   end

   // load, read and frame select control
   always_comb begin
      cur_b_in    = cur_b_ff;
      load_pos_in = load_pos_ff;
      read_pos_in = read_pos_ff;
      pend_in     = pend_ff && !rsp_tready;
      last_in     = last_ff;
      sel_in      = sel_ff;
      if (load_acc) begin
         if (load_addr == '0) begin
            cur_b_in    = 1'b0;
            read_pos_in = '0;
         end
         if (load_last) begin
            load_pos_in = '0;
            cur_b_in    = 1'b0;
         end else begin
            load_pos_in = load_addr + ADDR_W'(1);
         end
      end
      if (read_acc) begin
         pend_in     = 1'b1;
         last_in     = read_last;
         sel_in      = cur_b_ff;
         read_pos_in = read_last ? '0 : read_addr + ADDR_W'(1);
      end
      if (eng.done) begin
         cur_b_in = eng.final_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_count_ff <= RST_PASS_COUNT;
         blend_step_ff <= RST_BLEND_STEP;
         width_ff      <= RST_WIDTH;
         height_ff     <= RST_HEIGHT;
         cur_b_ff      <= 1'b0;
         load_pos_ff   <= '0;
         read_pos_ff   <= '0;
         pend_ff       <= 1'b0;
      end else begin
         pass_count_ff <= pass_count_in;
         blend_step_ff <= blend_step_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         cur_b_ff      <= cur_b_in;
         load_pos_ff   <= load_pos_in;
         read_pos_ff   <= read_pos_in;
         pend_ff       <= pend_in;
      end
      last_ff <= last_in;
      sel_ff  <= sel_in;
   end

   // frame memory port steering
   always_comb begin
      if (eng.busy) begin
         a_we    = eng_wr_en && eng.src_b;
         a_waddr = eng_wr_addr;
         a_wdata = eng_wr_data;
         a_re    = eng_rd_en && !eng.src_b;
         a_raddr = eng_rd_addr;
         b_re    = eng_rd_en && eng.src_b;
         b_raddr = eng_rd_addr;
      end else begin
         a_we    = load_acc;
         a_waddr = load_addr;
         a_wdata = req_tdata;
         a_re    = read_acc && !cur_b_ff;
         a_raddr = read_addr;
         b_re    = read_acc && cur_b_ff;
         b_raddr = read_addr;
      end
      b_we        = eng.busy && eng_wr_en && !eng.src_b;
      eng_rd_data = eng.src_b ? b_q : a_q;
   end

   sfi_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_frame_a (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_en   (a_re),
      .rd_addr (a_raddr),
      .rd_data (a_q)
   );

   sfi_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_frame_b (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (eng_wr_addr),
      .wr_data (eng_wr_data),
      .rd_en   (b_re),
      .rd_addr (b_raddr),
      .rd_data (b_q)
   );

   sfi_engine #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .XW         (XW),
      .YW         (YW),
      .ADDR_W     (ADDR_W)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .eff_w      (eff_w),
      .eff_h      (eff_h),
      .step       (step_sat),
      .pass_count (pass_count_ff),
      .status     (eng),
      .rd_en      (eng_rd_en),
      .rd_addr    (eng_rd_addr),
      .rd_data    (eng_rd_data),
      .wr_en      (eng_wr_en),
      .wr_addr    (eng_wr_addr),
      .wr_data    (eng_wr_data)
   );

   // result beat straight from the registered read data
   assign rsp_tvalid = pend_ff;
   assign rsp_tdata  = sel_ff ? b_q : a_q;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire
